[design/jhdp_pkg.sv]
// ----------------------------------------------------------------------------
// jhdp_pkg
// Shared types and codes for the JPEG header dimension parser.
// ----------------------------------------------------------------------------
package jhdp_pkg;

	// status codes
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_BAD_SOI  = 4'd1;
	localparam logic [3:0] ST_NO_FF    = 4'd2;
	localparam logic [3:0] ST_PROG     = 4'd3;
	localparam logic [3:0] ST_SCAN     = 4'd4;
	localparam logic [3:0] ST_EOI      = 4'd5;
	localparam logic [3:0] ST_UNKNOWN  = 4'd6;
	localparam logic [3:0] ST_TRUNC    = 4'd7;
	localparam logic [3:0] ST_BAD_COMP = 4'd8;

	// marker bytes
	localparam logic [7:0] MK_FF     = 8'hff;
	localparam logic [7:0] MK_SOI    = 8'hd8;
	localparam logic [7:0] MK_APP_LO = 8'he0;
	localparam logic [7:0] MK_APP_HI = 8'hef;
	localparam logic [7:0] MK_COM    = 8'hfe;
	localparam logic [7:0] MK_DQT    = 8'hdb;
	localparam logic [7:0] MK_DHT    = 8'hc4;
	localparam logic [7:0] MK_SOF0   = 8'hc0;
	localparam logic [7:0] MK_SOF2   = 8'hc2;
	localparam logic [7:0] MK_SOS    = 8'hda;
	localparam logic [7:0] MK_EOI    = 8'hd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
		logic       last_of_file;
	} src_word_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] image_height;
		logic [15:0] image_width;
		logic [7:0]  component_count;
		logic [7:0]  marker_code;
	} res_word_t;

endpackage

[design/jpeg_header_dimension_parser.sv]
// ----------------------------------------------------------------------------
// jpeg_header_dimension_parser
// Result: registered; a deciding byte shows it in the cycle after it is accepted.
// Throughput: one byte per cycle; the single result register stalls the
// byte side only while it is full and its word is not being taken.
// Reset: asynchronous, clears the parse phase to start-of-file and empties
// the result register.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_parser import jhdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_word_t src_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	logic      take;
	logic      fire;
	res_word_t result;
	logic      res_valid_q;
	res_word_t res_word_q;

	assign src_stall = res_valid_q && res_stall;
	assign take      = src_valid && !src_stall;

	jhdp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (src_word),
		.fire   (fire),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && fire) begin
			res_word_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

[design/jhdp_parse.sv]
// ----------------------------------------------------------------------------
// jhdp_parse
// Marker-segment scanner: phase, skip counter and dimension holds; decides
// the result for each accepted byte.
// ----------------------------------------------------------------------------
module jhdp_parse import jhdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  src_word_t word,
	output logic      fire,
	output res_word_t result
);

	typedef enum logic [3:0] {
		PH_SOI0   = 4'd0,
		PH_SOI1   = 4'd1,
		PH_MFF    = 4'd2,
		PH_MCODE  = 4'd3,
		PH_LENH   = 4'd4,
		PH_LENL   = 4'd5,
		PH_SKIP   = 4'd6,
		PH_SOFPAD = 4'd7,
		PH_HH     = 4'd8,
		PH_HL     = 4'd9,
		PH_WH     = 4'd10,
		PH_WL     = 4'd11,
		PH_COMP   = 4'd12,
		PH_IDLE   = 4'd13
	} phase_t;

	phase_t      phase_q;
	logic [15:0] skip_q;
	logic [7:0]  len_hi_q;
	logic [15:0] height_q;
	logic [15:0] width_q;
	logic [7:0]  marker_q;

	phase_t      eff_phase, n_phase;
	logic [15:0] eff_skip, n_skip, dec_skip, seg_len;
	logic [7:0]  eff_len_hi, n_len_hi;
	logic [15:0] eff_height, n_height;
	logic [15:0] eff_width, n_width;
	logic [7:0]  eff_marker, n_marker;
	logic        done, idle_hit, with_dims;
	logic [3:0]  status;
	logic [7:0]  b;

	always_comb begin
		b = word.data_byte;
		// a new file wipes everything before the byte is looked at
		if (word.first_of_file) begin
			eff_phase  = PH_SOI0;
			eff_skip   = '0;
			eff_len_hi = '0;
			eff_height = '0;
			eff_width  = '0;
			eff_marker = '0;
		end else begin
			eff_phase  = phase_q;
			eff_skip   = skip_q;
			eff_len_hi = len_hi_q;
			eff_height = height_q;
			eff_width  = width_q;
			eff_marker = marker_q;
		end
		n_phase   = eff_phase;
		n_skip    = eff_skip;
		n_len_hi  = eff_len_hi;
		n_height  = eff_height;
		n_width   = eff_width;
		n_marker  = eff_marker;
		done      = 1'b0;
		idle_hit  = 1'b0;
		with_dims = 1'b0;
		status    = ST_OK;
		seg_len   = {eff_len_hi, b};
		dec_skip  = (eff_skip != 16'd0) ? (eff_skip - 16'd1) : eff_skip;

		case (eff_phase)
			PH_SOI0: begin
				if (b != MK_FF) begin
					done   = 1'b1;
					status = ST_BAD_SOI;
				end else begin
					n_phase = PH_SOI1;
				end
			end
			PH_SOI1: begin
				if (b != MK_SOI) begin
					done   = 1'b1;
					status = ST_BAD_SOI;
				end else begin
					n_phase = PH_MFF;
				end
			end
			PH_MFF: begin
				if (b != MK_FF) begin
					done   = 1'b1;
					status = ST_NO_FF;
				end else begin
					n_phase = PH_MCODE;
				end
			end
			PH_MCODE: begin
				n_marker = b;
				if ((b >= MK_APP_LO && b <= MK_APP_HI) || b == MK_COM || b == MK_DQT ||
				    b == MK_DHT) begin
					n_phase = PH_LENH;
				end else if (b == MK_SOF0) begin
					n_skip  = 16'd3;
					n_phase = PH_SOFPAD;
				end else if (b == MK_SOF2) begin
					done   = 1'b1;
					status = ST_PROG;
				end else if (b == MK_SOS) begin
					done   = 1'b1;
					status = ST_SCAN;
				end else if (b == MK_EOI) begin
					done   = 1'b1;
					status = ST_EOI;
				end else begin
					done   = 1'b1;
					status = ST_UNKNOWN;
				end
			end
			PH_LENH: begin
				n_len_hi = b;
				n_phase  = PH_LENL;
			end
			PH_LENL: begin
				// length counts its own two bytes
				if (seg_len > 16'd2) begin
					n_skip  = seg_len - 16'd2;
					n_phase = PH_SKIP;
				end else begin
					n_skip  = '0;
					n_phase = PH_MFF;
				end
			end
			PH_SKIP, PH_SOFPAD: begin
				n_skip = dec_skip;
				if (dec_skip == 16'd0) begin
					n_phase = (eff_phase == PH_SOFPAD) ? PH_HH : PH_MFF;
				end
			end
			PH_HH: begin
				n_height = {b, 8'h00};
				n_phase  = PH_HL;
			end
			PH_HL: begin
				n_height = eff_height | {8'h00, b};
				n_phase  = PH_WH;
			end
			PH_WH: begin
				n_width = {b, 8'h00};
				n_phase = PH_WL;
			end
			PH_WL: begin
				n_width = eff_width | {8'h00, b};
				n_phase = PH_COMP;
			end
			PH_COMP: begin
				done      = 1'b1;
				with_dims = 1'b1;
				status    = (b == 8'd1 || b == 8'd3) ? ST_OK : ST_BAD_COMP;
			end
			default: begin
				idle_hit = 1'b1;
				n_phase  = PH_IDLE;
			end
		endcase

		if (!done && !idle_hit && word.last_of_file) begin
			done   = 1'b1;
			status = ST_TRUNC;
		end
		if (done) begin
			n_phase = PH_IDLE;
		end

		fire                   = done;
		result.status          = status;
		result.image_height    = with_dims ? eff_height : 16'd0;
		result.image_width     = with_dims ? eff_width : 16'd0;
		result.component_count = with_dims ? b : 8'd0;
		result.marker_code     = n_marker;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOI0;
			skip_q   <= '0;
			len_hi_q <= '0;
			height_q <= '0;
			width_q  <= '0;
			marker_q <= '0;
		end else if (take) begin
			phase_q  <= n_phase;
			skip_q   <= n_skip;
			len_hi_q <= n_len_hi;
			height_q <= n_height;
			width_q  <= n_width;
			marker_q <= n_marker;
		end
	end

endmodule

[design/jhdp_checker.sv]
// ----------------------------------------------------------------------------
// jhdp_checker
// Port-level checks on the header parser, bound to the top level.
// ----------------------------------------------------------------------------
module jhdp_checker import jhdp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input src_word_t src_word,
	input logic      res_valid,
	input logic      res_stall,
	input res_word_t res_word
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// byte side only backs up behind a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid && res_stall)
		else $error("byte side stalled without a pending result");

	// dimensions only travel with a finished SOF0
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.status != ST_OK && res_word.status != ST_BAD_COMP |->
		res_word.image_height == 16'd0 && res_word.image_width == 16'd0 &&
		res_word.component_count == 8'd0)
		else $error("dimensions reported with an error status");

	// a new file that does not open with FF fails right away
	assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && src_word.first_of_file && src_word.data_byte != MK_FF |=>
		res_valid && res_word.status == ST_BAD_SOI)
		else $error("bad first byte not reported");

endmodule

bind jpeg_header_dimension_parser jhdp_checker u_jhdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_word  (src_word),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

[bench/jhdp_report_checker.sv]
// ----------------------------------------------------------------------------
// jhdp_report_checker
// Watches both channels of the JPEG header dimension parser, predicts
// the report for every accepted byte and compares each accepted report
// field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module jhdp_report_checker import jhdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_stall,
	input  src_word_t src_word,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_word_t res_word,
	output int        fail_count,
	output int        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		PH_SOI0, PH_SOI1, PH_MFF, PH_MCODE, PH_LENH, PH_LENL, PH_SKIP,
		PH_SOFPAD, PH_HH, PH_HL, PH_WH, PH_WL, PH_COMP, PH_IDLE
	} parse_phase_t;

	parse_phase_t phase;
	logic [15:0]  skip_left;
	logic [7:0]   len_hi;
	logic [15:0]  height_q;
	logic [15:0]  width_q;
	logic [7:0]   marker_q;

	res_word_t expected_reports[$];
	int        errs;

	function automatic void clear_parse();
		phase     = PH_SOI0;
		skip_left = '0;
		len_hi    = '0;
		height_q  = '0;
		width_q   = '0;
		marker_q  = '0;
	endfunction

	// advance the parser by one byte; returns 1 when the byte decides a report
	function automatic bit parse_byte(input src_word_t w, output res_word_t rep);
		logic [7:0]  b;
		logic [15:0] seg_len;
		logic [3:0]  st;
		bit          done;
		bit          dims;
		b    = w.data_byte;
		st   = ST_OK;
		done = 1'b0;
		dims = 1'b0;
		rep  = '0;
		if (w.first_of_file)
			clear_parse();
		// after a report only a new file wakes the parser
		if (phase == PH_IDLE)
			return 1'b0;
		case (phase)
			PH_SOI0: begin
				if (b != MK_FF) begin
					done = 1'b1;
					st   = ST_BAD_SOI;
				end else
					phase = PH_SOI1;
			end
			PH_SOI1: begin
				if (b != MK_SOI) begin
					done = 1'b1;
					st   = ST_BAD_SOI;
				end else
					phase = PH_MFF;
			end
			PH_MFF: begin
				if (b != MK_FF) begin
					done = 1'b1;
					st   = ST_NO_FF;
				end else
					phase = PH_MCODE;
			end
			PH_MCODE: begin
				marker_q = b;
				if ((b >= MK_APP_LO && b <= MK_APP_HI) || b == MK_COM || b == MK_DQT ||
						b == MK_DHT)
					phase = PH_LENH;
				else if (b == MK_SOF0) begin
					skip_left = 16'd3;
					phase     = PH_SOFPAD;
				end else begin
					done = 1'b1;
					if (b == MK_SOF2)
						st = ST_PROG;
					else if (b == MK_SOS)
						st = ST_SCAN;
					else if (b == MK_EOI)
						st = ST_EOI;
					else
						st = ST_UNKNOWN;
				end
			end
			PH_LENH: begin
				len_hi = b;
				phase  = PH_LENL;
			end
			PH_LENL: begin
				seg_len = {len_hi, b};
				// the length counts its own two bytes
				if (seg_len > 16'd2) begin
					skip_left = seg_len - 16'd2;
					phase     = PH_SKIP;
				end else begin
					skip_left = '0;
					phase     = PH_MFF;
				end
			end
			PH_SKIP, PH_SOFPAD: begin
				if (skip_left != '0)
					skip_left = skip_left - 16'd1;
				if (skip_left == '0)
					phase = (phase == PH_SOFPAD) ? PH_HH : PH_MFF;
			end
			PH_HH: begin
				height_q = {b, 8'h00};
				phase    = PH_HL;
			end
			PH_HL: begin
				height_q[7:0] = b;
				phase         = PH_WH;
			end
			PH_WH: begin
				width_q = {b, 8'h00};
				phase   = PH_WL;
			end
			PH_WL: begin
				width_q[7:0] = b;
				phase        = PH_COMP;
			end
			PH_COMP: begin
				done = 1'b1;
				dims = 1'b1;
				st   = (b == 8'd1 || b == 8'd3) ? ST_OK : ST_BAD_COMP;
			end
			default: begin
				phase = PH_IDLE;
			end
		endcase
		// end of stream on a byte that decided nothing
		if (!done && w.last_of_file) begin
			done = 1'b1;
			st   = ST_TRUNC;
		end
		if (done) begin
			rep.status          = st;
			rep.image_height    = dims ? height_q : 16'd0;
			rep.image_width     = dims ? width_q : 16'd0;
			rep.component_count = dims ? b : 8'd0;
			rep.marker_code     = marker_q;
			phase               = PH_IDLE;
		end
		return done;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		res_word_t made;
		if (!arst_n) begin
			clear_parse();
			expected_reports.delete();
			errs          = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			// reports first, so a word accepted on this edge cannot answer itself
			if (res_valid && !res_stall) begin
				if (expected_reports.size() == 0) begin
					if (errs < 10)
						$display("%0t: unexpected report st=%0d h=%0d w=%0d n=%0d mk=%02h",
							$realtime, res_word.status, res_word.image_height,
							res_word.image_width, res_word.component_count,
							res_word.marker_code);
					errs++;
				end else begin
					want = expected_reports.pop_front();
					if (want.status !== res_word.status ||
							want.image_height !== res_word.image_height ||
							want.image_width !== res_word.image_width ||
							want.component_count !== res_word.component_count ||
							want.marker_code !== res_word.marker_code) begin
						if (errs < 10)
							$display({"%0t: report mismatch exp st=%0d h=%0d w=%0d n=%0d mk=%02h",
								" got st=%0d h=%0d w=%0d n=%0d mk=%02h"}, $realtime,
								want.status, want.image_height, want.image_width,
								want.component_count, want.marker_code,
								res_word.status, res_word.image_height,
								res_word.image_width, res_word.component_count,
								res_word.marker_code);
						errs++;
					end
				end
			end
			if (src_valid && !src_stall) begin
				if (parse_byte(src_word, made))
					expected_reports.push_back(made);
			end
			fail_count    <= errs;
			pending_count <= expected_reports.size();
		end
	end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Byte-stream stimulus for the JPEG header dimension parser: directed files
// for every status and corner, then random files, mostly well formed with
// random segments, plus noise, cut and corrupted files, under several
// sender idle and receiver stall mixes. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench import jhdp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_BYTES  = 250;
	localparam int DRAIN_CYCLES = 8;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_word_t src_word;
	logic      res_valid;
	logic      res_stall;
	res_word_t res_word;
	int        fail_count;
	int        pending_count;

	int         src_idle_pct  = 0;
	int         res_stall_pct = 0;
	int         sent_count    = 0;
	logic [7:0] file_bytes[$];

	jpeg_header_dimension_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	jhdp_report_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.src_word      (src_word),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_word      (res_word),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			res_stall <= ($urandom_range(99) < res_stall_pct);
		end
	end

	// ends the run when nothing moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic first_flag,
			input logic last_flag);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= '{data_byte: b, first_of_file: first_flag, last_of_file: last_flag};
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic stream_file(input bit set_first, input bit set_last);
		int k;
		for (k = 0; k < file_bytes.size(); k++)
			send_byte(file_bytes[k], set_first && k == 0,
				set_last && k == file_bytes.size() - 1);
	endtask

	function automatic logic [7:0] pick_dim_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// builds one random file into file_bytes; end_flag says whether its last
	// word carries the end-of-file mark
	task automatic build_random_file(output bit end_flag);
		int         seg_len;
		int         i;
		int         cut;
		int         ending;
		logic [7:0] code;
		logic [7:0] ends_q[$];
		file_bytes = {};
		end_flag   = ($urandom_range(9) != 0);
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(8, 1))
				file_bytes.push_back(8'($urandom));
			return;
		end
		file_bytes = {MK_FF, MK_SOI};
		repeat ($urandom_range(3)) begin
			case ($urandom_range(3))
				0: code = MK_APP_LO + 8'($urandom_range(15));
				1: code = MK_COM;
				2: code = MK_DQT;
				default: code = MK_DHT;
			endcase
			seg_len = ($urandom_range(39) == 0) ? $urandom_range(700, 256)
				: $urandom_range(14);
			file_bytes.push_back(MK_FF);
			file_bytes.push_back(code);
			file_bytes.push_back(8'(seg_len >> 8));
			file_bytes.push_back(8'(seg_len));
			for (i = 2; i < seg_len; i++)
				file_bytes.push_back(8'($urandom));
		end
		ending = $urandom_range(9);
		if (ending <= 5) begin
			file_bytes.push_back(MK_FF);
			file_bytes.push_back(MK_SOF0);
			repeat (3)
				file_bytes.push_back(8'($urandom));
			repeat (4)
				file_bytes.push_back(pick_dim_byte());
			if ($urandom_range(9) < 7)
				file_bytes.push_back($urandom_range(1) ? 8'd3 : 8'd1);
			else
				file_bytes.push_back(8'($urandom));
		end else if (ending == 6) begin
			ends_q = {MK_SOF2, MK_SOS, MK_EOI};
			file_bytes.push_back(MK_FF);
			file_bytes.push_back(ends_q[$urandom_range(2)]);
		end else if (ending == 7) begin
			file_bytes.push_back(MK_FF);
			file_bytes.push_back(8'($urandom));
		end else if (ending == 8)
			file_bytes.push_back(8'($urandom));
		// corrupt or cut a few of the well-formed files
		if ($urandom_range(99) < 8)
			file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
		if ($urandom_range(99) < 8) begin
			cut        = $urandom_range(file_bytes.size() - 1);
			file_bytes = file_bytes[0:cut];
		end
	endtask

	initial begin
		int phase_idx;
		int goal;
		bit end_flag;
		int i;
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_word  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// first word after reset without the new-file mark, then a word that
		// must be ignored once the report is out
		file_bytes = {8'h00};
		stream_file(1'b0, 1'b1);
		send_byte(MK_FF, 1'b0, 1'b1);
		file_bytes = {MK_FF, 8'h00};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, 8'h12};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_SOF2};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_SOS};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_EOI};
		stream_file(1'b1, 1'b1);
		file_bytes = {MK_FF, MK_SOI, MK_FF, 8'h01};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF};
		stream_file(1'b1, 1'b1);
		file_bytes = {MK_FF, MK_SOI, MK_FF};
		stream_file(1'b1, 1'b1);
		// short lengths 0, 2, 3 and 1, then full-scale dimensions
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_APP_LO, 8'h00, 8'h00,
			MK_FF, MK_COM, 8'h00, 8'h02, MK_FF, MK_DQT, 8'h00, 8'h03, 8'haa,
			MK_FF, MK_DHT, 8'h00, 8'h01, MK_FF, MK_SOF0, 8'h00, 8'h11, 8'h08,
			8'hff, 8'hff, 8'hff, 8'hff, 8'd3};
		stream_file(1'b1, 1'b1);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_SOF0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'd1};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_SOF0, 8'hff, 8'hff, 8'hff,
			8'h12, 8'h34, 8'h56, 8'h78, 8'h00};
		stream_file(1'b1, 1'b0);
		file_bytes[11] = 8'hff;
		stream_file(1'b1, 1'b1);
		// end of stream inside the SOF0 pad and inside a skipped segment
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_SOF0, 8'h00};
		stream_file(1'b1, 1'b1);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_APP_HI, 8'h00, 8'h10, 8'h11, 8'h22};
		stream_file(1'b1, 1'b1);
		// new file in the middle of a segment restarts the parse
		file_bytes = {MK_FF, MK_SOI, MK_FF, 8'he5, 8'h00, 8'h08, 8'h01};
		stream_file(1'b1, 1'b0);
		file_bytes = {MK_FF, MK_SOI, MK_FF, MK_EOI};
		stream_file(1'b1, 1'b0);
		// segment whose length needs the high byte
		file_bytes = {MK_FF, MK_SOI, MK_FF, 8'he1, 8'h01, 8'h00};
		for (i = 0; i < 254; i++)
			file_bytes.push_back(8'($urandom));
		file_bytes.push_back(MK_FF);
		file_bytes.push_back(MK_EOI);
		stream_file(1'b1, 1'b0);

		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin
					src_idle_pct  = 0;
					res_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 67;
					res_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					res_stall_pct = 67;
				end
				default: begin
					src_idle_pct  = 17;
					res_stall_pct = 17;
				end
			endcase
			goal = sent_count + PHASE_BYTES;
			while (sent_count < goal) begin
				build_random_file(end_flag);
				stream_file(1'b1, end_flag);
				// stray words after a file, usually ignored by an idle parser
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(3, 1))
						send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
			end
		end
		src_valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[jpeg_header_dimension_parser.f]
design/jhdp_pkg.sv
design/jhdp_parse.sv
design/jpeg_header_dimension_parser.sv
design/jhdp_checker.sv
bench/jhdp_report_checker.sv
bench/testbench.sv
